### rtl/two_sweep_line_rasterizer_macros.svh
// Assertion macros for the two-sweep line rasterizer.
`ifndef TWO_SWEEP_LINE_RASTERIZER_MACROS_SVH
`define TWO_SWEEP_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSLR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tslr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSLR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tslr check failed");

`endif

### rtl/tslr_pkg.sv
// Shared types and constants for the two-sweep line rasterizer.
`default_nettype none

package tslr_pkg;

    localparam int COORD_W  = 5;
    localparam int COLOUR_W = 24;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int DIV_STEPS = COORD_W;

    localparam logic [0:0] REG_PEN_COLOUR = 1'b0;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [COLOUR_W-1:0] colour_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_item_t;

    typedef struct packed {
        coord_t  pixel_x;
        coord_t  pixel_y;
        colour_t pixel_colour;
        logic    last_pixel;
    } pix_item_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic step1;
        logic step2;
    } cmd_t;

    typedef struct packed {
        logic last1;
        logic last2;
    } stat_t;

endpackage

`default_nettype wire

### rtl/tslr_div.sv
// Restoring divider, one quotient bit per cycle while step is high, for the slope increment.
`default_nettype none

module tslr_div
(
    input  wire logic            clk,
    input  wire logic            init,
    input  wire logic            step,
    input  wire tslr_pkg::coord_t dividend,
    input  wire tslr_pkg::coord_t divisor,
    output tslr_pkg::coord_t     quot,
    output tslr_pkg::coord_t     rem
);

    localparam int W = tslr_pkg::COORD_W;

    tslr_pkg::coord_t acc_reg, acc_next;
    tslr_pkg::coord_t rem_reg, rem_next;
    tslr_pkg::coord_t den_reg;
    logic [W:0]       rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh   = {rem_reg, acc_reg[W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? W'(rem_sh - {1'b0, den_reg}) : rem_sh[W-1:0];
        acc_next = {acc_reg[W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = acc_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### rtl/tslr_ctrl.sv
// Sequencer: setup division, x sweep, y sweep.
`default_nettype none

module tslr_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire tslr_pkg::stat_t stat,
    output tslr_pkg::cmd_t      cmd,
    output logic                busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SW1  = 2'd2;
    localparam logic [1:0] S_SW2  = 2'd3;

    localparam int CNT_W = $clog2(tslr_pkg::DIV_STEPS);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(tslr_pkg::DIV_STEPS - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_SW1;
                end
            end
            S_SW1:
            begin
                cmd.step1 = 1'b1;
                if (stat.last1)
                begin
                    state_next = S_SW2;
                end
            end
            S_SW2:
            begin
                cmd.step2 = 1'b1;
                if (stat.last2)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### rtl/tslr_dp.sv
// Datapath: endpoint setup, incremental quotient/remainder stepping, pixel register.
`default_nettype none

module tslr_dp
#(
    parameter int CANVAS_SIZE = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tslr_pkg::cmd_t    cmd,
    input  wire tslr_pkg::seg_item_t seg,
    input  wire tslr_pkg::colour_t colour,
    output tslr_pkg::stat_t        stat,
    output tslr_pkg::pix_item_t    pixel,
    output logic                   pixel_valid
);

    localparam int W = tslr_pkg::COORD_W;
    localparam tslr_pkg::coord_t COORD_MAX = W'(CANVAS_SIZE - 1);

    typedef struct packed {
        tslr_pkg::coord_t t;
        tslr_pkg::coord_t q;
        tslr_pkg::coord_t r;
        tslr_pkg::coord_t hi;
        tslr_pkg::coord_t den;
        logic             neg;
    } sweep_t;

    function automatic tslr_pkg::coord_t clamp(input tslr_pkg::coord_t v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // quotient += floor(inc/den), remainder += inc mod den, carry on wrap
    function automatic sweep_t advance(input sweep_t s, input tslr_pkg::coord_t dq,
                                       input tslr_pkg::coord_t dr);
        logic [W:0]       qs;
        tslr_pkg::coord_t rs;
        logic [W:0]       rsum;
        logic             wrap;
        logic [W+1:0]     qsum;
        sweep_t           n;
        n = s;
        if (!s.neg)
        begin
            qs = {1'b0, dq};
            rs = dr;
        end
        else if (dr == '0)
        begin
            qs = -{1'b0, dq};
            rs = '0;
        end
        else
        begin
            qs = ~{1'b0, dq};
            rs = s.den - dr;
        end
        rsum = {1'b0, s.r} + {1'b0, rs};
        wrap = rsum >= {1'b0, s.den};
        qsum = {2'b00, s.q} + {qs[W], qs} + {{(W+1){1'b0}}, wrap};
        n.t  = s.t + W'(1);
        n.r  = wrap ? W'(rsum - {1'b0, s.den}) : rsum[W-1:0];
        n.q  = qsum[W-1:0];
        return n;
    endfunction

    tslr_pkg::coord_t x1, y1, x2, y2;
    tslr_pkg::coord_t xa, xb, ya, yb, ta, tb, pa, pb;
    tslr_pkg::coord_t mag1, mag2;
    logic             x_fwd, y_fwd;
    sweep_t           init1, init2;
    sweep_t           sw1_reg, sw1_next, sw2_reg, sw2_next;
    tslr_pkg::coord_t q1, r1, q2, r2;
    tslr_pkg::pix_item_t pix_reg;
    logic             valid_reg;

    always_comb
    begin
        x1 = clamp(seg.start_x);
        y1 = clamp(seg.start_y);
        x2 = clamp(seg.end_x);
        y2 = clamp(seg.end_y);

        x_fwd = x1 < x2;
        xa = x_fwd ? x1 : x2;
        xb = x_fwd ? x2 : x1;
        ya = x_fwd ? y1 : y2;
        yb = x_fwd ? y2 : y1;
        init1.t   = xa;
        init1.q   = ya;
        init1.r   = '0;
        init1.hi  = xb;
        init1.den = xb - xa;
        init1.neg = yb < ya;
        mag1      = init1.neg ? (ya - yb) : (yb - ya);

        // equal y keeps the first endpoint so a flat segment lands on start_x
        y_fwd = y1 <= y2;
        ta = y_fwd ? y1 : y2;
        tb = y_fwd ? y2 : y1;
        pa = y_fwd ? x1 : x2;
        pb = y_fwd ? x2 : x1;
        init2.t   = ta;
        init2.q   = pa;
        init2.r   = '0;
        init2.hi  = tb;
        init2.den = tb - ta;
        init2.neg = pb < pa;
        mag2      = init2.neg ? (pa - pb) : (pb - pa);
    end

    tslr_div u_div1
    (
        .clk      (clk),
        .init     (cmd.load),
        .step     (cmd.div_step),
        .dividend (mag1),
        .divisor  (init1.den),
        .quot     (q1),
        .rem      (r1)
    );

    tslr_div u_div2
    (
        .clk      (clk),
        .init     (cmd.load),
        .step     (cmd.div_step),
        .dividend (mag2),
        .divisor  (init2.den),
        .quot     (q2),
        .rem      (r2)
    );

    always_comb
    begin
        sw1_next = sw1_reg;
        sw2_next = sw2_reg;
        if (cmd.load)
        begin
            sw1_next = init1;
            sw2_next = init2;
        end
        else
        begin
            if (cmd.step1)
            begin
                sw1_next = advance(sw1_reg, q1, r1);
            end
            if (cmd.step2)
            begin
                sw2_next = advance(sw2_reg, q2, r2);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sw1_reg <= sw1_next;
        sw2_reg <= sw2_next;
        if (cmd.step1)
        begin
            pix_reg.pixel_x      <= sw1_reg.t;
            pix_reg.pixel_y      <= sw1_reg.q;
            pix_reg.pixel_colour <= colour;
            pix_reg.last_pixel   <= 1'b0;
        end
        else if (cmd.step2)
        begin
            pix_reg.pixel_x      <= sw2_reg.q;
            pix_reg.pixel_y      <= sw2_reg.t;
            pix_reg.pixel_colour <= colour;
            pix_reg.last_pixel   <= stat.last2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.step1 | cmd.step2;
        end
    end

    assign stat.last1  = (sw1_reg.t == sw1_reg.hi);
    assign stat.last2  = (sw2_reg.t == sw2_reg.hi);
    assign pixel       = pix_reg;
    assign pixel_valid = valid_reg;

endmodule

`default_nettype wire

### rtl/two_sweep_line_rasterizer.sv
// Top level of the two-sweep line rasterizer: pen register, sequencer, datapath.
`default_nettype none
//
// A segment item is taken on segment when start is high and busy is low.
// The block then sweeps x across the segment, one pixel per cycle, and
// after that sweeps y, one pixel per cycle; each pixel is shown on pixel
// for one cycle with pixel_valid high and must be taken in that cycle.
// Steps per segment: a load, then the slope dividers (one quotient bit per
// cycle, both sweeps in parallel), then |dx|+1 x-sweep pixels and |dy|+1
// y-sweep pixels. busy falls in the cycle the last pixel is shown, so the
// next segment may be accepted then.
// Coordinates above CANVAS_SIZE-1 saturate. The pen colour is written over
// the APB port (any address with paddr[2] low) and is copied into each
// pixel; the user must write it only while idle, which the block itself
// does not enforce. Reset returns the sequencer to idle, drops pixel_valid
// and clears the pen colour to 0.
//

`include "two_sweep_line_rasterizer_macros.svh"

module two_sweep_line_rasterizer
#(
    parameter int CANVAS_SIZE = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire tslr_pkg::seg_item_t           segment,
    output logic                               pixel_valid,
    output tslr_pkg::pix_item_t                pixel,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tslr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tslr_pkg::DATA_W-1:0]   pwdata,
    output logic [tslr_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    tslr_pkg::colour_t pen_reg;
    tslr_pkg::cmd_t    cmd;
    tslr_pkg::stat_t   stat;
    logic              pen_sel;

    assign pready  = 1'b1;
    assign pen_sel = (paddr[tslr_pkg::ADDR_W-1:2] == tslr_pkg::REG_PEN_COLOUR);
    assign prdata  = pen_sel ? {{(tslr_pkg::DATA_W - tslr_pkg::COLOUR_W){1'b0}}, pen_reg}
                             : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= '0;
        end
        else if (psel && penable && pwrite && pen_sel)
        begin
            pen_reg <= pwdata[tslr_pkg::COLOUR_W-1:0];
        end
    end

    tslr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tslr_dp
    #(
        .CANVAS_SIZE (CANVAS_SIZE)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .seg         (segment),
        .colour      (pen_reg),
        .stat        (stat),
        .pixel       (pixel),
        .pixel_valid (pixel_valid)
    );

    `TSLR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `TSLR_ASSERT_IMP(a_valid_while_busy, pixel_valid, $past(busy))
    `TSLR_ASSERT_IMP(a_last_ends_item, pixel_valid && pixel.last_pixel, !busy)

endmodule

`default_nettype wire
